// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/plci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plci_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int DT_W      = 24;
   localparam int ERR_W     = DATA_W + 1;
   localparam int ACC_W     = 48;
   localparam int ACC_LO_W  = ACC_W / 2;
   localparam int PROD_W    = DATA_W + ERR_W;
   localparam int DTE_W     = DT_W + ERR_W;
   localparam int DELTA_W   = DTE_W - FRAC_BITS;
   localparam int DL_W      = DELTA_W / 2;
   localparam int DH_W      = DELTA_W - DL_W;
   localparam int KL_W      = DATA_W + DL_W + 1;
   localparam int KH_W      = DATA_W + DH_W;
   localparam int KD_W      = DATA_W + DELTA_W;
   localparam int PI_W      = DATA_W + ACC_W;
   localparam int PI_SUM_W  = ((KD_W > PI_W) ? KD_W : PI_W) + 1;
   localparam int ACC_SUM_W = ((DELTA_W > ACC_W) ? DELTA_W : ACC_W) + 1;
   localparam int RAW_W     = ACC_W + 2;
   localparam int RCL_W     = DATA_W + ACC_LO_W + 1;
   localparam int RCH_W     = DATA_W + ACC_W - ACC_LO_W;
   localparam int REQ_W     = ((4 * DATA_W + DT_W + 7) / 8) * 8;
   localparam int RSP_W     = ((DATA_W + 7) / 8) * 8;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INTEGRAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DERIV     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MAX      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DRIVE_MIN      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_ENABLE    = 3'd6;

   typedef enum logic [STATUS_W-1:0] {
      ST_IN_RANGE = 2'd0,
      ST_HIGH     = 2'd1,
      ST_LOW      = 2'd2,
      ST_OFF      = 2'd3
   } plci_status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_prop;
      logic signed [DATA_W-1:0] gain_integral;
      logic signed [DATA_W-1:0] gain_deriv;
      logic signed [DATA_W-1:0] neutral_offset;
      logic signed [DATA_W-1:0] drive_max;
      logic signed [DATA_W-1:0] drive_min;
      logic                     loop_enable;
   } plci_cfg_type;

   typedef struct packed {
      logic ld0;
      logic ld1;
      logic ld2;
      logic ld3;
   } plci_adv_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] setpoint_rate;
      logic signed [DATA_W-1:0] measured;
      logic signed [DATA_W-1:0] measured_rate;
      logic        [DT_W-1:0]   elapsed;
   } plci_s0_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] setpoint;
      logic signed [PROD_W-1:0] p_prod;
      logic signed [PROD_W-1:0] d_prod;
      logic signed [DTE_W-1:0]  dte;
   } plci_s1_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  setpoint;
      logic signed [RAW_W-1:0]   pd;
      logic signed [DELTA_W-1:0] delta;
      logic signed [KL_W-1:0]    kl;
      logic signed [KH_W-1:0]    kh;
   } plci_s2_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  setpoint;
      logic signed [RAW_W-1:0]   pd;
      logic signed [DELTA_W-1:0] delta;
      logic signed [KD_W-1:0]    kd;
   } plci_s3_type;

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [PI_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      if (v > PI_W'(ACC_MAX)) begin
         r = ACC_MAX;
      end else if (v < PI_W'(ACC_MIN)) begin
         r = ACC_MIN;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/plci_front.sv
`timescale 1ns / 1ps
`default_nettype none

module plci_front (
   input  wire logic                        clock,
   input  wire logic [plci_pkg::REQ_W-1:0]  req_tdata,
   input  wire plci_pkg::plci_adv_type      adv,
   input  wire plci_pkg::plci_cfg_type      cfg,
   output plci_pkg::plci_s3_type            s3
);

   plci_pkg::plci_s0_type s0_in, s0_ff;
   plci_pkg::plci_s1_type s1_in, s1_ff;
   plci_pkg::plci_s2_type s2_in, s2_ff;
   plci_pkg::plci_s3_type s3_in, s3_ff;

   logic signed [plci_pkg::ERR_W-1:0]   err;
   logic signed [plci_pkg::ERR_W-1:0]   rerr;
   logic signed [plci_pkg::PROD_W-1:0]  p_sh;
   logic signed [plci_pkg::PROD_W-1:0]  d_sh;
   logic signed [plci_pkg::ACC_W-1:0]   p_term;
   logic signed [plci_pkg::ACC_W-1:0]   d_term;
   logic        [plci_pkg::DL_W-1:0]    dl;
   logic signed [plci_pkg::DH_W-1:0]    dh;

   always_comb begin
      s0_in.setpoint      = req_tdata[plci_pkg::DATA_W-1:0];
      s0_in.setpoint_rate = req_tdata[2*plci_pkg::DATA_W-1:plci_pkg::DATA_W];
      s0_in.measured      = req_tdata[3*plci_pkg::DATA_W-1:2*plci_pkg::DATA_W];
      s0_in.measured_rate = req_tdata[4*plci_pkg::DATA_W-1:3*plci_pkg::DATA_W];
      s0_in.elapsed       = req_tdata[4*plci_pkg::DATA_W+plci_pkg::DT_W-1:4*plci_pkg::DATA_W];
   end

   // errors kept exact, then the three input-side products
   always_comb begin
      err  = plci_pkg::ERR_W'(s0_ff.setpoint) - plci_pkg::ERR_W'(s0_ff.measured);
      rerr = plci_pkg::ERR_W'(s0_ff.setpoint_rate) - plci_pkg::ERR_W'(s0_ff.measured_rate);
      s1_in.setpoint = s0_ff.setpoint;
      s1_in.p_prod   = cfg.gain_prop * err;
      s1_in.d_prod   = cfg.gain_deriv * rerr;
      s1_in.dte      = $signed({1'b0, s0_ff.elapsed}) * err;
   end

   // scale and saturate, sum the static terms, split the integral gain product
   always_comb begin
      p_sh   = s1_ff.p_prod >>> plci_pkg::FRAC_BITS;
      d_sh   = s1_ff.d_prod >>> plci_pkg::FRAC_BITS;
      p_term = plci_pkg::sat_acc(plci_pkg::PI_W'(p_sh));
      d_term = plci_pkg::sat_acc(plci_pkg::PI_W'(d_sh));
      s2_in.setpoint = s1_ff.setpoint;
      s2_in.pd       = plci_pkg::RAW_W'(p_term) + plci_pkg::RAW_W'(d_term)
                     + plci_pkg::RAW_W'(cfg.neutral_offset);
      s2_in.delta    = plci_pkg::DELTA_W'(s1_ff.dte >>> plci_pkg::FRAC_BITS);
      dl             = s2_in.delta[plci_pkg::DL_W-1:0];
      dh             = s2_in.delta[plci_pkg::DELTA_W-1:plci_pkg::DL_W];
      s2_in.kl       = cfg.gain_integral * $signed({1'b0, dl});
      s2_in.kh       = cfg.gain_integral * dh;
   end

   always_comb begin
      s3_in.setpoint = s2_ff.setpoint;
      s3_in.pd       = s2_ff.pd;
      s3_in.delta    = s2_ff.delta;
      s3_in.kd       = (plci_pkg::KD_W'(s2_ff.kh) <<< plci_pkg::DL_W)
                     + plci_pkg::KD_W'(s2_ff.kl);
   end

   always_ff @(posedge clock) begin
      if (adv.ld0) begin
         s0_ff <= s0_in;
      end
      if (adv.ld1) begin
         s1_ff <= s1_in;
      end
      if (adv.ld2) begin
         s2_ff <= s2_in;
      end
      if (adv.ld3) begin
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

`default_nettype wire

// File: hw/rtl/plci_loop.sv
`timescale 1ns / 1ps
`default_nettype none

module plci_loop (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              ld_out,
   input  wire logic                              ki_write,
   input  wire plci_pkg::plci_cfg_type            cfg,
   input  wire plci_pkg::plci_s3_type             s3,
   output logic signed [plci_pkg::DATA_W-1:0]     drive,
   output plci_pkg::plci_status_type              status
);

   typedef enum logic [1:0] {
      RC_IDLE,
      RC_MUL,
      RC_SUM
   } rc_state_type;

   rc_state_type rc_state_ff;

   // integral_acc and its exact product with the integral gain
   logic signed [plci_pkg::ACC_W-1:0]     acc_ff, acc_in, acc_eff, acc_new;
   logic signed [plci_pkg::PI_W-1:0]      pi_ff, pi_in, pi_eff, pi_new, pi_sh;
   logic signed [plci_pkg::DATA_W-1:0]    last_sp_ff, last_sp_in;
   logic signed [plci_pkg::DATA_W-1:0]    drive_ff, drive_in;
   plci_pkg::plci_status_type             status_ff, status_in;
   logic signed [plci_pkg::RCL_W-1:0]     rc_lo_ff, rc_lo_in;
   logic signed [plci_pkg::RCH_W-1:0]     rc_hi_ff, rc_hi_in;

   logic                                  clear;
   logic signed [plci_pkg::ACC_W-1:0]     iterm;
   logic signed [plci_pkg::RAW_W-1:0]     raw, hi_lim, lo_lim;
   logic signed [plci_pkg::ACC_SUM_W-1:0] acc_sum;
   logic                                  acc_hi_sat, acc_lo_sat;
   logic signed [plci_pkg::PI_SUM_W-1:0]  pi_sum;
   logic signed [plci_pkg::PI_W-1:0]      ki_max, ki_min, pi_rebuilt;

   always_comb begin
      clear   = (s3.setpoint != last_sp_ff);
      acc_eff = clear ? '0 : acc_ff;
      pi_eff  = clear ? '0 : pi_ff;
      pi_sh   = pi_eff >>> plci_pkg::FRAC_BITS;
      iterm   = plci_pkg::sat_acc(pi_sh);
      raw     = s3.pd + plci_pkg::RAW_W'(iterm);
      hi_lim  = plci_pkg::RAW_W'(cfg.drive_max);
      lo_lim  = plci_pkg::RAW_W'(cfg.drive_min);

      acc_sum    = plci_pkg::ACC_SUM_W'(acc_eff) + plci_pkg::ACC_SUM_W'(s3.delta);
      acc_hi_sat = acc_sum > plci_pkg::ACC_SUM_W'(plci_pkg::ACC_MAX);
      acc_lo_sat = acc_sum < plci_pkg::ACC_SUM_W'(plci_pkg::ACC_MIN);
      acc_new    = plci_pkg::sat_acc(plci_pkg::PI_W'(acc_sum));

      ki_max = (plci_pkg::PI_W'(cfg.gain_integral) <<< (plci_pkg::ACC_W - 1))
             - plci_pkg::PI_W'(cfg.gain_integral);
      ki_min = -(plci_pkg::PI_W'(cfg.gain_integral) <<< (plci_pkg::ACC_W - 1));
      pi_sum = plci_pkg::PI_SUM_W'(pi_eff) + plci_pkg::PI_SUM_W'(s3.kd);
      priority if (acc_hi_sat) begin
         pi_new = ki_max;
      end else if (acc_lo_sat) begin
         pi_new = ki_min;
      end else begin
         pi_new = pi_sum[plci_pkg::PI_W-1:0];
      end
   end

   always_comb begin
      acc_in     = acc_eff;
      pi_in      = pi_eff;
      last_sp_in = last_sp_ff;
      drive_in   = '0;
      status_in  = plci_pkg::ST_OFF;
      if (cfg.loop_enable) begin
         last_sp_in = s3.setpoint;
         priority if (raw > hi_lim) begin
            drive_in  = cfg.drive_max;
            status_in = plci_pkg::ST_HIGH;
         end else if (raw < lo_lim) begin
            drive_in  = cfg.drive_min;
            status_in = plci_pkg::ST_LOW;
         end else begin
            drive_in  = raw[plci_pkg::DATA_W-1:0];
            status_in = plci_pkg::ST_IN_RANGE;
            acc_in    = acc_new;
            pi_in     = pi_new;
         end
      end
   end

   // rebuild the gain product after a new integral gain
   always_comb begin
      rc_lo_in   = cfg.gain_integral * $signed({1'b0, acc_ff[plci_pkg::ACC_LO_W-1:0]});
      rc_hi_in   = cfg.gain_integral
                 * $signed(acc_ff[plci_pkg::ACC_W-1:plci_pkg::ACC_LO_W]);
      pi_rebuilt = (plci_pkg::PI_W'(rc_hi_ff) <<< plci_pkg::ACC_LO_W)
                 + plci_pkg::PI_W'(rc_lo_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_state_ff <= RC_IDLE;
         acc_ff      <= '0;
         pi_ff       <= '0;
         last_sp_ff  <= '0;
      end else begin
         if (ki_write) begin
            rc_state_ff <= RC_MUL;
         end else begin
            unique case (rc_state_ff)
               RC_IDLE: begin
                  rc_state_ff <= RC_IDLE;
               end
               RC_MUL: begin
                  rc_state_ff <= RC_SUM;
               end
               RC_SUM: begin
                  rc_state_ff <= RC_IDLE;
               end
               default: begin
                  rc_state_ff <= RC_IDLE;
               end
            endcase
         end
         if (ld_out) begin
            acc_ff     <= acc_in;
            pi_ff      <= pi_in;
            last_sp_ff <= last_sp_in;
         end else if (rc_state_ff == RC_SUM) begin
            pi_ff      <= pi_rebuilt;
         end
      end
      if (rc_state_ff == RC_MUL) begin
         rc_lo_ff <= rc_lo_in;
         rc_hi_ff <= rc_hi_in;
      end
      if (ld_out) begin
         drive_ff  <= drive_in;
         status_ff <= status_in;
      end
   end

   assign drive  = drive_ff;
   assign status = status_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pid_loop_clamped_integrator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   ports      direction  payload
// req_      tdata      in         setpoint, setpoint_rate, measured, measured_rate, elapsed
// rsp_      tdata/user out        drive / limit_status
// csr_      we/index   in         seven control registers, write only
//
// One item per cycle sustained while results are taken; a result passes the input register,
// three product and scaling stages, then the loop stage with the result register. The
// integrator closes in the loop stage alone.
// Synchronous reset clears the pipeline valids, the registers, the integrator and the
// last setpoint. A stalled result holds every stage behind it; bubbles collapse.
// A write to gain_integral rebuilds the integral product in the RC_MUL and RC_SUM states.

module pid_loop_clamped_integrator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // setpoint, setpoint_rate, measured, measured_rate, elapsed
   input  wire logic [plci_pkg::REQ_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // drive
   output logic [plci_pkg::RSP_W-1:0]           rsp_tdata,
   // limit_status
   output logic [plci_pkg::STATUS_W-1:0]        rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [plci_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [plci_pkg::DATA_W-1:0]     csr_data
);

   plci_pkg::plci_cfg_type    cfg_ff;
   plci_pkg::plci_adv_type    adv;
   plci_pkg::plci_s3_type     s3;
   plci_pkg::plci_status_type status;

   logic signed [plci_pkg::DATA_W-1:0] drive;
   logic v0_ff, v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic v0_in, v1_in, v2_in, v3_in, out_valid_in;
   logic rdy0, rdy1, rdy2, rdy3, adv_out, ld_out, ki_write;

   always_comb begin
      adv_out = !out_valid_ff || rsp_tready;
      rdy3    = !v3_ff || adv_out;
      rdy2    = !v2_ff || rdy3;
      rdy1    = !v1_ff || rdy2;
      rdy0    = !v0_ff || rdy1;
      ld_out  = v3_ff && adv_out;
      adv.ld3 = v2_ff && rdy3;
      adv.ld2 = v1_ff && rdy2;
      adv.ld1 = v0_ff && rdy1;
      adv.ld0 = req_tvalid && rdy0;

      v0_in        = adv.ld0 || (v0_ff && !adv.ld1);
      v1_in        = adv.ld1 || (v1_ff && !adv.ld2);
      v2_in        = adv.ld2 || (v2_ff && !adv.ld3);
      v3_in        = adv.ld3 || (v3_ff && !ld_out);
      out_valid_in = ld_out || (out_valid_ff && !rsp_tready);

      ki_write = csr_we && (csr_index == plci_pkg::REG_GAIN_INTEGRAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               plci_pkg::REG_GAIN_PROP:      cfg_ff.gain_prop      <= csr_data;
               plci_pkg::REG_GAIN_INTEGRAL:  cfg_ff.gain_integral  <= csr_data;
               plci_pkg::REG_GAIN_DERIV:     cfg_ff.gain_deriv     <= csr_data;
               plci_pkg::REG_NEUTRAL_OFFSET: cfg_ff.neutral_offset <= csr_data;
               plci_pkg::REG_DRIVE_MAX:      cfg_ff.drive_max      <= csr_data;
               plci_pkg::REG_DRIVE_MIN:      cfg_ff.drive_min      <= csr_data;
               plci_pkg::REG_LOOP_ENABLE:    cfg_ff.loop_enable    <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   plci_front u_front (
      .clock     (clock),
      .req_tdata (req_tdata),
      .adv       (adv),
      .cfg       (cfg_ff),
      .s3        (s3)
   );

   plci_loop u_loop (
      .clock    (clock),
      .reset    (reset),
      .ld_out   (ld_out),
      .ki_write (ki_write),
      .cfg      (cfg_ff),
      .s3       (s3),
      .drive    (drive),
      .status   (status)
   );

   assign req_tready = rdy0;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = plci_pkg::RSP_W'($unsigned(drive));
   assign rsp_tuser  = status;

endmodule

`default_nettype wire

// File: hw/rtl/plci_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module plci_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [plci_pkg::RSP_W-1:0]      rsp_tdata,
   input wire logic [plci_pkg::STATUS_W-1:0]   rsp_tuser
);

   // hold a stalled result
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // reset empties the pipeline and opens the input
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

   // inactive loop drives zero
   `ASSERT_CLK(a_off_zero, clock, reset, rsp_tvalid && (rsp_tuser == plci_pkg::ST_OFF) |-> (rsp_tdata == '0), "inactive item with nonzero drive")

endmodule

bind pid_loop_clamped_integrator plci_checker u_checker (.*);

`default_nettype wire

// File: tb/plci_drive_checker.sv
`timescale 1ns / 1ps

module plci_drive_checker
   import plci_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   // setpoint, setpoint_rate, measured, measured_rate, elapsed
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // drive
   input  logic [RSP_W-1:0]     rsp_tdata,
   // limit_status
   input  logic [STATUS_W-1:0]  rsp_tuser,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data,
   output int                   fail_count,
   output int                   drives_pending
);

   typedef struct {
      logic signed [DATA_W-1:0] drive;
      plci_status_type          status;
   } drive_result_type;

   plci_cfg_type             loop_cfg;
   logic signed [ACC_W-1:0]  integ_acc;
   logic [DATA_W-1:0]        held_setpoint;
   drive_result_type         expected_drives[$];
   int                       mismatch_count = 0;

   function automatic logic signed [ACC_W-1:0] clamp_acc(input logic signed [127:0] v);
      logic signed [127:0] upper;
      logic signed [127:0] lower;
      upper = ACC_MAX;
      lower = ACC_MIN;
      if (v > upper) return ACC_MAX;
      if (v < lower) return ACC_MIN;
      return v[ACC_W-1:0];
   endfunction

   // gain times operand, floored back to the fixed-point scale, saturated to the acc range
   function automatic logic signed [ACC_W-1:0] gain_term(input logic signed [DATA_W-1:0] gain,
                                                          input logic signed [ACC_W-1:0] operand);
      logic signed [127:0] g;
      logic signed [127:0] x;
      g = gain;
      x = operand;
      return clamp_acc((g * x) >>> FRAC_BITS);
   endfunction

   task automatic predict_drive(input logic [REQ_W-1:0] item, output drive_result_type r);
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] setpoint_rate;
      logic signed [DATA_W-1:0] measured;
      logic signed [DATA_W-1:0] measured_rate;
      logic        [DT_W-1:0]   elapsed;
      logic signed [ACC_W-1:0]  err;
      logic signed [ACC_W-1:0]  rate_err;
      logic signed [DT_W:0]     dt_s;
      logic signed [63:0]       raw;
      logic signed [63:0]       step;
      setpoint      = item[DATA_W-1:0];
      setpoint_rate = item[2*DATA_W-1:DATA_W];
      measured      = item[3*DATA_W-1:2*DATA_W];
      measured_rate = item[4*DATA_W-1:3*DATA_W];
      elapsed       = item[4*DATA_W+DT_W-1:4*DATA_W];
      if (setpoint != held_setpoint) integ_acc = '0;
      if (!loop_cfg.loop_enable) begin
         r.drive  = '0;
         r.status = ST_OFF;
      end else begin
         err      = setpoint - measured;
         rate_err = setpoint_rate - measured_rate;
         raw = gain_term($signed(loop_cfg.gain_prop), err)
             + gain_term($signed(loop_cfg.gain_deriv), rate_err)
             + gain_term($signed(loop_cfg.gain_integral), integ_acc)
             + $signed(loop_cfg.neutral_offset);
         if (raw > $signed(loop_cfg.drive_max)) begin
            r.drive  = loop_cfg.drive_max;
            r.status = ST_HIGH;
         end else if (raw < $signed(loop_cfg.drive_min)) begin
            r.drive  = loop_cfg.drive_min;
            r.status = ST_LOW;
         end else begin
            r.drive   = raw[DATA_W-1:0];
            r.status  = ST_IN_RANGE;
            dt_s      = {1'b0, elapsed};
            step      = (dt_s * err) >>> FRAC_BITS;
            integ_acc = clamp_acc(integ_acc + step);
         end
         held_setpoint = setpoint;
      end
   endtask

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         loop_cfg      = '0;
         integ_acc     = '0;
         held_setpoint = '0;
         expected_drives.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_drives.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected drive item: expected none actual %h/%0d",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_drives.pop_front();
               if (rsp_tdata[DATA_W-1:0] !== want.drive) begin
                  mismatch_count++;
                  $display("%0t: drive mismatch: expected %h actual %h",
                           $time, want.drive, rsp_tdata[DATA_W-1:0]);
               end
               if (rsp_tuser !== want.status) begin
                  mismatch_count++;
                  $display("%0t: limit_status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_drive(req_tdata, want);
            expected_drives.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               REG_GAIN_PROP:      loop_cfg.gain_prop      = csr_data;
               REG_GAIN_INTEGRAL:  loop_cfg.gain_integral  = csr_data;
               REG_GAIN_DERIV:     loop_cfg.gain_deriv     = csr_data;
               REG_NEUTRAL_OFFSET: loop_cfg.neutral_offset = csr_data;
               REG_DRIVE_MAX:      loop_cfg.drive_max      = csr_data;
               REG_DRIVE_MIN:      loop_cfg.drive_min      = csr_data;
               REG_LOOP_ENABLE:    loop_cfg.loop_enable    = csr_data[0];
               default: ;
            endcase
         end
      end
      drives_pending <= expected_drives.size();
      fail_count     <= mismatch_count;
   end

endmodule

// File: tb/pid_loop_clamped_integrator_tb.sv
`timescale 1ns / 1ps

module pid_loop_clamped_integrator_tb;
   import plci_pkg::*;

   localparam int LATENCY_CYCLES = 8;
   localparam int HANG_LIMIT     = 2000;
   localparam int IDLE_PCT       = 9;
   localparam int WINDUP_ITEMS   = 150;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 140;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   localparam logic [DATA_W-1:0] Q_ONE    = 32'h0001_0000;
   localparam logic [DATA_W-1:0] Q_HALF   = 32'h0000_8000;
   localparam logic [DATA_W-1:0] Q_FOURTH = 32'h0000_4000;
   localparam logic [DATA_W-1:0] POS_FULL = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] NEG_FULL = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [DT_W-1:0]   DT_ONE   = 24'h01_0000;
   localparam logic [DT_W-1:0]   DT_FULL  = 24'hFF_FFFF;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_W-1:0]         rsp_tdata;
   logic [STATUS_W-1:0]      rsp_tuser;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DATA_W-1:0]        csr_data;
   int                       fail_count;
   int                       drives_pending;
   logic                     calm;
   int                       hang_cycles = 0;
   logic signed [DATA_W-1:0] run_setpoint;

   always #10 clock = ~clock;

   pid_loop_clamped_integrator dut (.*);

   plci_drive_checker checker_i (.*);

   always @(posedge clock) rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         hang_cycles <= 0;
      end else if (hang_cycles == HANG_LIMIT) begin
         $display("pid_loop_clamped_integrator regression: fail");
         $finish;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
   end

   function automatic plci_s0_type make_sample(input logic [DATA_W-1:0] sp, sr, ms, mr,
                                                input logic [DT_W-1:0] el);
      plci_s0_type s;
      s.setpoint      = sp;
      s.setpoint_rate = sr;
      s.measured      = ms;
      s.measured_rate = mr;
      s.elapsed       = el;
      return s;
   endfunction

   function automatic plci_cfg_type make_settings(input logic [DATA_W-1:0] kp, ki, kd, offs,
                                                  hi, lo, input logic en);
      plci_cfg_type c;
      c.gain_prop      = kp;
      c.gain_integral  = ki;
      c.gain_deriv     = kd;
      c.neutral_offset = offs;
      c.drive_max      = hi;
      c.drive_min      = lo;
      c.loop_enable    = en;
      return c;
   endfunction

   function automatic logic [DATA_W-1:0] scaled_rand(input int min_shift);
      return $signed($urandom()) >>> $urandom_range(31, min_shift);
   endfunction

   function automatic logic [DATA_W-1:0] corner_word();
      case ($urandom_range(4))
         0:       return POS_FULL;
         1:       return NEG_FULL;
         2:       return '0;
         3:       return ALL_ONES;
         default: return 32'd1;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] corner_elapsed();
      case ($urandom_range(3))
         0:       return '0;
         1:       return DT_FULL;
         2:       return 24'd1;
         default: return DT_W'($urandom());
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_gain();
      if ($urandom_range(9) == 0) return $urandom();
      return scaled_rand(13);
   endfunction

   function automatic plci_cfg_type random_settings();
      plci_cfg_type c;
      c.gain_prop      = random_gain();
      c.gain_integral  = random_gain();
      c.gain_deriv     = random_gain();
      c.neutral_offset = scaled_rand(10);
      case ($urandom_range(5))
         0: begin
            c.drive_max = POS_FULL;
            c.drive_min = NEG_FULL;
         end
         1: begin
            c.drive_max = -$signed(DATA_W'($urandom_range(32'h0040_0000)));
            c.drive_min = $urandom_range(32'h0040_0000);
         end
         default: begin
            c.drive_max = $urandom_range(32'h0040_0000);
            c.drive_min = -$signed(DATA_W'($urandom_range(32'h0040_0000)));
         end
      endcase
      c.loop_enable = ($urandom_range(5) != 0);
      return c;
   endfunction

   // mostly tracking runs around a held setpoint, with noise and corner items mixed in
   function automatic plci_s0_type random_sample();
      int pick;
      logic [DT_W-1:0] el;
      pick = $urandom_range(99);
      if (pick < 10)
         return make_sample($urandom(), $urandom(), $urandom(), $urandom(), DT_W'($urandom()));
      if (pick < 15)
         return make_sample(corner_word(), corner_word(), corner_word(), corner_word(),
                            corner_elapsed());
      if ($urandom_range(11) == 0) run_setpoint = scaled_rand(8);
      el = ($urandom_range(9) == 0) ? DT_W'($urandom()) : DT_W'($urandom_range(24'h4000));
      return make_sample(run_setpoint, scaled_rand(14), run_setpoint + scaled_rand(12),
                         scaled_rand(14), el);
   endfunction

   task automatic send_sample(input plci_s0_type s);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {s.elapsed, s.measured_rate, s.measured, s.setpoint_rate, s.setpoint};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // drain the loop, then reprogram every register
   task automatic apply_settings(input plci_cfg_type c);
      logic [DATA_W-1:0] filler;
      filler = $urandom();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      write_reg(REG_GAIN_PROP, c.gain_prop);
      write_reg(REG_GAIN_INTEGRAL, c.gain_integral);
      write_reg(REG_GAIN_DERIV, c.gain_deriv);
      write_reg(REG_NEUTRAL_OFFSET, c.neutral_offset);
      write_reg(REG_DRIVE_MAX, c.drive_max);
      write_reg(REG_DRIVE_MIN, c.drive_min);
      if ($urandom_range(2) == 0) write_reg(REG_UNMAPPED, $urandom());
      write_reg(REG_LOOP_ENABLE, {filler[DATA_W-1:1], c.loop_enable});
      csr_we <= 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      calm         = 1'b0;
      run_setpoint = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // loop off out of reset
      send_sample(make_sample(32'h0005_0000, 0, 0, 0, DT_ONE));
      send_sample(make_sample(0, 0, 0, 0, 0));

      apply_settings(make_settings(Q_ONE, Q_HALF, Q_FOURTH, 32'h100, POS_FULL, NEG_FULL, 1'b1));
      send_sample(make_sample(POS_FULL, POS_FULL, NEG_FULL, NEG_FULL, DT_FULL));
      send_sample(make_sample(NEG_FULL, NEG_FULL, POS_FULL, POS_FULL, DT_FULL));
      send_sample(make_sample(0, 0, 0, 0, 0));
      repeat (3) send_sample(make_sample(Q_ONE, Q_HALF, 0, 0, DT_ONE));
      send_sample(make_sample(32'hFFFF_0000, 0, 0, Q_ONE, DT_ONE));

      // saturating gain products
      apply_settings(make_settings(POS_FULL, NEG_FULL, POS_FULL, 0, POS_FULL, NEG_FULL, 1'b1));
      send_sample(make_sample(POS_FULL, NEG_FULL, NEG_FULL, POS_FULL, 0));
      send_sample(make_sample(NEG_FULL, POS_FULL, POS_FULL, NEG_FULL, 0));
      send_sample(make_sample(32'h4000_0000, 0, 0, 0, 0));

      // inverted limits
      apply_settings(make_settings(Q_ONE, 0, 0, 0, 32'hFFFF_0000, Q_ONE, 1'b1));
      send_sample(make_sample(32'h0002_0000, 0, 0, 0, DT_ONE));
      send_sample(make_sample(32'hFFFE_0000, 0, 0, 0, DT_ONE));
      send_sample(make_sample(32'hFFFF_0000, 0, 0, 0, DT_ONE));

      // narrow window: integrate, clamp high, clamp low, integrate
      apply_settings(make_settings(Q_ONE, Q_ONE, 0, 0, 32'h0003_0000, 32'hFFFD_0000, 1'b1));
      send_sample(make_sample(32'h0002_0000, 0, 0, 0, DT_ONE));
      send_sample(make_sample(32'h0002_0000, 0, 0, 0, DT_ONE));
      send_sample(make_sample(32'hFFFC_0000, 0, 0, 0, DT_ONE));
      send_sample(make_sample(Q_ONE, 0, 0, 0, DT_ONE));

      // a new setpoint while off clears the integrator but keeps the held setpoint
      apply_settings(make_settings(Q_ONE, Q_ONE, 0, 0, 32'h0003_0000, 32'hFFFD_0000, 1'b0));
      send_sample(make_sample(32'h0007_0000, 0, 0, 0, DT_FULL));
      apply_settings(make_settings(Q_ONE, Q_ONE, 0, 0, 32'h0003_0000, 32'hFFFD_0000, 1'b1));
      send_sample(make_sample(Q_ONE, 0, 0, 0, 0));

      // drive the integrator into both rails
      apply_settings(make_settings(0, 0, 0, 0, POS_FULL, NEG_FULL, 1'b1));
      repeat (WINDUP_ITEMS)
         send_sample(make_sample(POS_FULL, $urandom(), NEG_FULL, $urandom(),
                                 DT_W'($urandom_range(24'hFF_FFFF, 24'hF0_0000))));
      apply_settings(make_settings(0, POS_FULL, 0, 0, POS_FULL, NEG_FULL, 1'b1));
      send_sample(make_sample(POS_FULL, 0, NEG_FULL, 0, 0));
      apply_settings(make_settings(0, 0, 0, 0, POS_FULL, NEG_FULL, 1'b1));
      repeat (WINDUP_ITEMS)
         send_sample(make_sample(NEG_FULL, $urandom(), POS_FULL, $urandom(),
                                 DT_W'($urandom_range(24'hFF_FFFF, 24'hF0_0000))));
      apply_settings(make_settings(0, POS_FULL, 0, 0, POS_FULL, NEG_FULL, 1'b1));
      send_sample(make_sample(NEG_FULL, 0, POS_FULL, 0, 0));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm <= (phase == 3);
         apply_settings(random_settings());
         repeat (PHASE_ITEMS) send_sample(random_sample());
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (LATENCY_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("pid_loop_clamped_integrator regression: pass");
      end else begin
         $display("pid_loop_clamped_integrator regression: fail");
      end
      $finish;
   end

endmodule
